// ===== rtl/rhht_pkg.sv =====
// Shared types and constants for the rectangle handle hit test pipeline.
package rhht_pkg;

  // Default coordinate width and the fixed field widths
  localparam int unsigned CoordWidthDef = 16;
  localparam int unsigned HsWidth       = 8;
  localparam int unsigned CodeWidth     = 4;
  localparam int unsigned RankWidth     = 2;

  localparam logic [HsWidth-1:0]   HsReset  = 8'd5;
  localparam logic [RankWidth-1:0] RankBox  = 2'd2;
  localparam logic [RankWidth-1:0] RankSpan = 2'd1;

  // Result codes
  typedef enum logic [CodeWidth-1:0] {
    HIT_NONE    = 4'd0,
    HIT_BODY    = 4'd1,
    HIT_HANDLE1 = 4'd2,
    HIT_HANDLE2 = 4'd3,
    HIT_HANDLE3 = 4'd4,
    HIT_HANDLE4 = 4'd5,
    HIT_LINE1   = 4'd6,
    HIT_LINE2   = 4'd7,
    HIT_LINE3   = 4'd8,
    HIT_LINE4   = 4'd9
  } hit_code_e;

  // Zone flags handed from the compare stage to the encoder
  typedef struct packed {
    logic [RankWidth-1:0] rank;
    logic                 hon;
    logic                 zero;
    logic                 near_xl;
    logic                 near_xr;
    logic                 near_yt;
    logic                 near_yb;
    logic                 in_x;
    logic                 in_y;
  } rhht_zone_t;

endpackage

// ===== rtl/rhht_span.sv =====
// Stage 1: far edges of the box, handle half-width and zero-size flag.
module rhht_span #(
  parameter int unsigned W = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [rhht_pkg::HsWidth-1:0]      handle_size_i,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [W-1:0]               cursor_x_i,
  input  logic signed [W-1:0]               cursor_y_i,
  input  logic signed [W-1:0]               box_left_i,
  input  logic signed [W-1:0]               box_top_i,
  input  logic [W-2:0]                      box_width_i,
  input  logic [W-2:0]                      box_height_i,
  input  logic [rhht_pkg::RankWidth-1:0]    box_rank_i,
  input  logic                              handles_on_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic signed [W-1:0]               x_o,
  output logic signed [W-1:0]               y_o,
  output logic signed [W-1:0]               px_o,
  output logic signed [W-1:0]               py_o,
  output logic signed [W:0]                 xr_o,
  output logic signed [W:0]                 yb_o,
  output logic [rhht_pkg::HsWidth-1:0]      h_o,
  output logic [rhht_pkg::RankWidth-1:0]    rank_o,
  output logic                              hon_o,
  output logic                              zero_o
);
  import rhht_pkg::*;

  // Width wide enough for both a box size and the handle size
  localparam int unsigned MW = ((W - 1) > HsWidth) ? (W - 1) : HsWidth;

  logic [MW-1:0]       pw_m, ph_m, hs_m, wh_min, h_m;
  logic signed [W:0]   xr_d, yb_d;
  logic                valid_q;
  logic                load;

  // Handle half-width: smallest of width, height and handle size
  assign pw_m   = MW'(box_width_i);
  assign ph_m   = MW'(box_height_i);
  assign hs_m   = MW'(handle_size_i);
  assign wh_min = (pw_m < ph_m) ? pw_m : ph_m;
  assign h_m    = (hs_m < wh_min) ? hs_m : wh_min;

  // Right and bottom edges, one bit wider so nothing wraps
  assign xr_d = (W+1)'(box_left_i) + $signed((W+1)'(box_width_i));
  assign yb_d = (W+1)'(box_top_i)  + $signed((W+1)'(box_height_i));

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      x_o    <= cursor_x_i;
      y_o    <= cursor_y_i;
      px_o   <= box_left_i;
      py_o   <= box_top_i;
      xr_o   <= xr_d;
      yb_o   <= yb_d;
      h_o    <= HsWidth'(h_m);
      rank_o <= box_rank_i;
      hon_o  <= handles_on_i;
      zero_o <= (box_width_i == '0) && (box_height_i == '0);
    end
  end

endmodule

// ===== rtl/rhht_diff.sv =====
// Stage 2: cursor offsets from the four box edges.
module rhht_diff #(
  parameter int unsigned W = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [W-1:0]               x_i,
  input  logic signed [W-1:0]               y_i,
  input  logic signed [W-1:0]               px_i,
  input  logic signed [W-1:0]               py_i,
  input  logic signed [W:0]                 xr_i,
  input  logic signed [W:0]                 yb_i,
  input  logic [rhht_pkg::HsWidth-1:0]      h_i,
  input  logic [rhht_pkg::RankWidth-1:0]    rank_i,
  input  logic                              hon_i,
  input  logic                              zero_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic signed [W+1:0]               dxl_o,
  output logic signed [W+1:0]               dxr_o,
  output logic signed [W+1:0]               dyt_o,
  output logic signed [W+1:0]               dyb_o,
  output logic [rhht_pkg::HsWidth-1:0]      h_o,
  output logic [rhht_pkg::RankWidth-1:0]    rank_o,
  output logic                              hon_o,
  output logic                              zero_o
);
  import rhht_pkg::*;

  logic valid_q;
  logic load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Offsets, two bits wider than a coordinate
  always_ff @(posedge clk_i) begin
    if (load) begin
      dxl_o  <= (W+2)'(x_i) - (W+2)'(px_i);
      dxr_o  <= (W+2)'(x_i) - (W+2)'(xr_i);
      dyt_o  <= (W+2)'(y_i) - (W+2)'(py_i);
      dyb_o  <= (W+2)'(y_i) - (W+2)'(yb_i);
      h_o    <= h_i;
      rank_o <= rank_i;
      hon_o  <= hon_i;
      zero_o <= zero_i;
    end
  end

endmodule

// ===== rtl/rhht_zone.sv =====
// Stage 3: handle-zone and inside tests on the edge offsets.
module rhht_zone #(
  parameter int unsigned W = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [W+1:0]               dxl_i,
  input  logic signed [W+1:0]               dxr_i,
  input  logic signed [W+1:0]               dyt_i,
  input  logic signed [W+1:0]               dyb_i,
  input  logic [rhht_pkg::HsWidth-1:0]      h_i,
  input  logic [rhht_pkg::RankWidth-1:0]    rank_i,
  input  logic                              hon_i,
  input  logic                              zero_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output rhht_pkg::rhht_zone_t              zone_o
);
  import rhht_pkg::*;

  logic signed [W+1:0] hx, hx_neg;
  rhht_zone_t          zone_d;
  logic                valid_q;
  logic                load;

  assign hx     = $signed((W+2)'(h_i));
  assign hx_neg = -hx;

  // Open window of half-width h around each edge, closed box span
  always_comb begin
    zone_d.rank    = rank_i;
    zone_d.hon     = hon_i;
    zone_d.zero    = zero_i;
    zone_d.near_xl = (dxl_i > hx_neg) && (dxl_i < hx);
    zone_d.near_xr = (dxr_i > hx_neg) && (dxr_i < hx);
    zone_d.near_yt = (dyt_i > hx_neg) && (dyt_i < hx);
    zone_d.near_yb = (dyb_i > hx_neg) && (dyb_i < hx);
    zone_d.in_x    = !dxl_i[W+1] && ((dxr_i == '0) || dxr_i[W+1]);
    zone_d.in_y    = !dyt_i[W+1] && ((dyb_i == '0) || dyb_i[W+1]);
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      zone_o <= zone_d;
    end
  end

endmodule

// ===== rtl/rhht_encode.sv =====
// Stage 4: priority encoder into the output register.
module rhht_encode (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  rhht_pkg::rhht_zone_t              zone_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output rhht_pkg::hit_code_e               code_o
);
  import rhht_pkg::*;

  hit_code_e code_d;
  logic      r2;
  logic      body;
  logic      valid_q;
  logic      load;

  assign r2   = (zone_i.rank == RankBox);
  assign body = (r2 && zone_i.in_x && zone_i.in_y)
             || ((zone_i.rank == RankSpan) && zone_i.in_x);

  // Zero-size box first, then corners, then side lines; span reports corners as lines
  always_comb begin
    code_d = body ? HIT_BODY : HIT_NONE;
    if (body && zone_i.hon) begin
      priority if (zone_i.zero) begin
        code_d = r2 ? HIT_HANDLE3 : HIT_LINE2;
      end else if (zone_i.near_xl && zone_i.near_yt) begin
        code_d = r2 ? HIT_HANDLE1 : HIT_LINE1;
      end else if (zone_i.near_xr && zone_i.near_yt) begin
        code_d = r2 ? HIT_HANDLE2 : HIT_LINE2;
      end else if (zone_i.near_xr && zone_i.near_yb) begin
        code_d = r2 ? HIT_HANDLE3 : HIT_LINE2;
      end else if (zone_i.near_xl && zone_i.near_yb) begin
        code_d = r2 ? HIT_HANDLE4 : HIT_LINE1;
      end else if (zone_i.near_xl && zone_i.in_y) begin
        code_d = HIT_LINE1;
      end else if (zone_i.near_xr && zone_i.in_y) begin
        code_d = HIT_LINE2;
      end else if (r2 && zone_i.near_yt && zone_i.in_x) begin
        code_d = HIT_LINE3;
      end else if (r2 && zone_i.near_yb && zone_i.in_x) begin
        code_d = HIT_LINE4;
      end else begin
        code_d = HIT_BODY;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      code_o <= code_d;
    end
  end

  // Unused ranks never hit anything
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (zone_i.rank != RankBox) && (zone_i.rank != RankSpan))
      |=> (code_o == HIT_NONE))
    else $error("hit on unused rank");

  // With handles off only body or none comes out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !zone_i.hon) |=> ((code_o == HIT_NONE) || (code_o == HIT_BODY)))
    else $error("handle code with handles off");

  // A span never reports a corner handle or a top or bottom line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (zone_i.rank == RankSpan))
      |=> ((code_o != HIT_HANDLE1) && (code_o != HIT_HANDLE2)
        && (code_o != HIT_HANDLE3) && (code_o != HIT_HANDLE4)
        && (code_o != HIT_LINE3) && (code_o != HIT_LINE4)))
    else $error("2-D code on span");

  // Outside the x span nothing but none
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !zone_i.in_x) |=> (code_o == HIT_NONE))
    else $error("hit outside x span");

endmodule

// ===== rtl/rect_handle_hit_test_unit.sv =====
// Top level of the rectangle handle hit test: ports, register and pipeline.
//
//   channel   dir  beat holds
//   s_axis    in   cursor point, box corner and size (tdata); rank, handles flag (tuser)
//   m_axis    out  hit code (tdata)
//   cfg       in   handle size, always ready
//
// Four register stages: edges and half-width, edge offsets, zone tests,
// encoder. One beat is taken every cycle unless downstream stalls.
// Each stage holds its beat while downstream stalls and accepts a new
// beat whenever it is empty or draining, so bubbles close up.
// Reset clears the valid bits and sets the handle size to 5.
module rect_handle_hit_test_unit #(
  parameter int unsigned COORD_WIDTH = rhht_pkg::CoordWidthDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [rhht_pkg::HsWidth-1:0]           cfg_data_i,
  // query stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // cursor_x, cursor_y, box_left, box_top, box_width, box_height, zero pad
  input  logic [((6*COORD_WIDTH-2+7)/8)*8-1:0]   s_axis_tdata,
  // box_rank, handles_on
  input  logic [2:0]                             s_axis_tuser,
  // result stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // hit_code, zero pad
  output logic [7:0]                             m_axis_tdata
);
  import rhht_pkg::*;

  localparam int unsigned W = COORD_WIDTH;

  logic [HsWidth-1:0] handle_size_q;

  // Unpacked query fields
  logic signed [W-1:0] cursor_x, cursor_y, box_left, box_top;
  logic [W-2:0]        box_width, box_height;

  // Stage 1 outputs
  logic                 s1_valid, s1_ready;
  logic signed [W-1:0]  s1_x, s1_y, s1_px, s1_py;
  logic signed [W:0]    s1_xr, s1_yb;
  logic [HsWidth-1:0]   s1_h;
  logic [RankWidth-1:0] s1_rank;
  logic                 s1_hon, s1_zero;

  // Stage 2 outputs
  logic                 s2_valid, s2_ready;
  logic signed [W+1:0]  s2_dxl, s2_dxr, s2_dyt, s2_dyb;
  logic [HsWidth-1:0]   s2_h;
  logic [RankWidth-1:0] s2_rank;
  logic                 s2_hon, s2_zero;

  // Stage 3 outputs
  logic                 s3_valid, s3_ready;
  rhht_zone_t           s3_zone;

  hit_code_e            code;

  // Handle size register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      handle_size_q <= HsReset;
    end else if (cfg_valid_i) begin
      handle_size_q <= cfg_data_i;
    end
  end

  // Field unpacking, lowest field first
  assign cursor_x   = s_axis_tdata[W-1:0];
  assign cursor_y   = s_axis_tdata[2*W-1:W];
  assign box_left   = s_axis_tdata[3*W-1:2*W];
  assign box_top    = s_axis_tdata[4*W-1:3*W];
  assign box_width  = s_axis_tdata[5*W-2:4*W];
  assign box_height = s_axis_tdata[6*W-3:5*W-1];

  rhht_span #(.W(W)) u_span (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .handle_size_i (handle_size_q),
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .cursor_x_i    (cursor_x),
    .cursor_y_i    (cursor_y),
    .box_left_i    (box_left),
    .box_top_i     (box_top),
    .box_width_i   (box_width),
    .box_height_i  (box_height),
    .box_rank_i    (s_axis_tuser[1:0]),
    .handles_on_i  (s_axis_tuser[2]),
    .valid_o       (s1_valid),
    .ready_i       (s1_ready),
    .x_o           (s1_x),
    .y_o           (s1_y),
    .px_o          (s1_px),
    .py_o          (s1_py),
    .xr_o          (s1_xr),
    .yb_o          (s1_yb),
    .h_o           (s1_h),
    .rank_o        (s1_rank),
    .hon_o         (s1_hon),
    .zero_o        (s1_zero)
  );

  rhht_diff #(.W(W)) u_diff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .x_i     (s1_x),
    .y_i     (s1_y),
    .px_i    (s1_px),
    .py_i    (s1_py),
    .xr_i    (s1_xr),
    .yb_i    (s1_yb),
    .h_i     (s1_h),
    .rank_i  (s1_rank),
    .hon_i   (s1_hon),
    .zero_i  (s1_zero),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .dxl_o   (s2_dxl),
    .dxr_o   (s2_dxr),
    .dyt_o   (s2_dyt),
    .dyb_o   (s2_dyb),
    .h_o     (s2_h),
    .rank_o  (s2_rank),
    .hon_o   (s2_hon),
    .zero_o  (s2_zero)
  );

  rhht_zone #(.W(W)) u_zone (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .dxl_i   (s2_dxl),
    .dxr_i   (s2_dxr),
    .dyt_i   (s2_dyt),
    .dyb_i   (s2_dyb),
    .h_i     (s2_h),
    .rank_i  (s2_rank),
    .hon_i   (s2_hon),
    .zero_i  (s2_zero),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .zone_o  (s3_zone)
  );

  rhht_encode u_encode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid),
    .ready_o (s3_ready),
    .zone_i  (s3_zone),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .code_o  (code)
  );

  assign m_axis_tdata = {4'b0000, code};

endmodule
